/* hw/rtl/c_sbc_pkg.sv */
// ---------------------------------------------------------------------------
// C source balance checker package
// Shared types, lexer state codes, result kinds and character constants.
// ---------------------------------------------------------------------------
package c_sbc_pkg;

    localparam int unsigned NUM_KINDS = 7;

    // lexer states
    localparam logic [3:0] ST_CODE      = 4'd0;
    localparam logic [3:0] ST_SLASH     = 4'd1;
    localparam logic [3:0] ST_STR       = 4'd2;
    localparam logic [3:0] ST_STR_ESC   = 4'd3;
    localparam logic [3:0] ST_CHR       = 4'd4;
    localparam logic [3:0] ST_CHR_ESC   = 4'd5;
    localparam logic [3:0] ST_CHR_CLOSE = 4'd6;
    localparam logic [3:0] ST_CHR_SKIP  = 4'd7;
    localparam logic [3:0] ST_BLK       = 4'd8;
    localparam logic [3:0] ST_BLK_STAR  = 4'd9;
    localparam logic [3:0] ST_LINE      = 4'd10;

    // result kinds
    localparam logic [2:0] KIND_STR_OPEN = 3'd0;
    localparam logic [2:0] KIND_BAD_CHR  = 3'd1;
    localparam logic [2:0] KIND_CMT_OPEN = 3'd2;
    localparam logic [2:0] KIND_PARENS   = 3'd3;
    localparam logic [2:0] KIND_BRACKETS = 3'd4;
    localparam logic [2:0] KIND_BRACES   = 3'd5;
    localparam logic [2:0] KIND_TOTAL    = 3'd6;

    // input function codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_EOT  = 1'b1;

    // characters
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [15:0] ERR_MAX = 16'd32767;

    // results raised by one transfer: one mask bit per kind, in kind order
    typedef struct packed {
        logic [NUM_KINDS-1:0] mask;
        logic [31:0]          line_number;
        logic signed [15:0]   paren;
        logic signed [15:0]   bracket;
        logic signed [15:0]   brace;
        logic [15:0]          total;
    } t_bundle;

endpackage

/* hw/rtl/c_sbc_lexer.sv */
// ---------------------------------------------------------------------------
// C source balance checker lexer
// Lexical state, open counts, line and error counters; one byte per cycle
// unless stalled; results of a transfer are held in a pending bundle register.
// ---------------------------------------------------------------------------
module c_sbc_lexer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [7:0]         i_text_byte,
    output logic               o_pend_valid,
    output c_sbc_pkg::t_bundle o_pend,
    input  logic               i_pend_take
);
    import c_sbc_pkg::*;

    typedef struct packed {
        logic [3:0]         state;
        logic signed [15:0] paren;
        logic signed [15:0] bracket;
        logic signed [15:0] brace;
        logic [31:0]        line;
        logic [15:0]        err;
    } t_lexst;

    function automatic logic signed [15:0] sat_inc(input logic signed [15:0] v);
        return (v != 16'sh7FFF) ? v + 16'sd1 : v;
    endfunction

    function automatic logic signed [15:0] sat_dec(input logic signed [15:0] v);
        return (v != 16'sh8000) ? v - 16'sd1 : v;
    endfunction

    function automatic logic [31:0] line_inc(input logic [31:0] v);
        return (v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
    endfunction

    function automatic logic [15:0] err_inc(input logic [15:0] v);
        return (v < ERR_MAX) ? v + 16'd1 : v;
    endfunction

    function automatic t_lexst code_byte(input t_lexst s, input logic [7:0] b);
        t_lexst t;
        t       = s;
        t.state = ST_CODE;
        case (b)
            CH_DQUOTE: t.state   = ST_STR;
            CH_SLASH:  t.state   = ST_SLASH;
            CH_SQUOTE: t.state   = ST_CHR;
            CH_NL:     t.line    = line_inc(s.line);
            CH_LPAREN: t.paren   = sat_inc(s.paren);
            CH_RPAREN: t.paren   = sat_dec(s.paren);
            CH_LBRACK: t.bracket = sat_inc(s.bracket);
            CH_RBRACK: t.bracket = sat_dec(s.bracket);
            CH_LBRACE: t.brace   = sat_inc(s.brace);
            CH_RBRACE: t.brace   = sat_dec(s.brace);
            default:   t.state   = ST_CODE;
        endcase
        return t;
    endfunction

    t_lexst  r_st, n_st, code_st, rst_st;
    t_bundle n_bnd, r_pend;
    logic    r_pend_v;
    logic    accept;
    logic    lit_err;
    logic [2:0]  err_cnt;
    logic [16:0] err_sum;

    assign o_in_stall   = r_pend_v && !i_pend_take;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_pend_valid = r_pend_v;
    assign o_pend       = r_pend;

    assign rst_st  = '{state: ST_CODE, paren: 16'sd0, bracket: 16'sd0, brace: 16'sd0,
                       line: 32'd1, err: 16'd0};
    assign code_st = code_byte(r_st, i_text_byte);

    always_comb begin
        n_st              = r_st;
        n_bnd             = '0;
        n_bnd.line_number = r_st.line;
        n_bnd.paren       = r_st.paren;
        n_bnd.bracket     = r_st.bracket;
        n_bnd.brace       = r_st.brace;
        lit_err           = 1'b0;
        err_cnt           = 3'd0;
        err_sum           = 17'd0;
        if (i_func == FUNC_BYTE) begin
            case (r_st.state)
                ST_CODE: begin
                    n_st = code_st;
                end
                ST_SLASH: begin
                    if (i_text_byte == CH_STAR) n_st.state = ST_BLK;
                    else if (i_text_byte == CH_SLASH) n_st.state = ST_LINE;
                    else n_st = code_st;
                end
                ST_STR: begin
                    if (i_text_byte == CH_BSLASH) n_st.state = ST_STR_ESC;
                    else if (i_text_byte == CH_DQUOTE) n_st.state = ST_CODE;
                end
                ST_STR_ESC: begin
                    n_st.state = ST_STR;
                end
                ST_CHR: begin
                    n_st.state = (i_text_byte == CH_BSLASH) ? ST_CHR_ESC : ST_CHR_CLOSE;
                end
                ST_CHR_ESC: begin
                    n_st.state = ST_CHR_CLOSE;
                end
                ST_CHR_CLOSE: begin
                    if (i_text_byte == CH_SQUOTE) begin
                        n_st.state = ST_CODE;
                    end else begin
                        n_st.err                 = err_inc(r_st.err);
                        n_st.state               = ST_CHR_SKIP;
                        n_bnd.mask[KIND_BAD_CHR] = 1'b1;
                    end
                end
                ST_CHR_SKIP: begin
                    if (i_text_byte == CH_SQUOTE) n_st.state = ST_CODE;
                end
                ST_BLK: begin
                    if (i_text_byte == CH_STAR) n_st.state = ST_BLK_STAR;
                    else if (i_text_byte == CH_NL) n_st.line = line_inc(r_st.line);
                end
                ST_BLK_STAR: begin
                    // any run of stars then a slash closes the comment
                    if (i_text_byte == CH_SLASH) begin
                        n_st.state = ST_CODE;
                    end else if (i_text_byte != CH_STAR) begin
                        if (i_text_byte == CH_NL) n_st.line = line_inc(r_st.line);
                        n_st.state = ST_BLK;
                    end
                end
                ST_LINE: begin
                    if (i_text_byte == CH_NL) begin
                        n_st.line  = line_inc(r_st.line);
                        n_st.state = ST_CODE;
                    end
                end
                default: begin
                    n_st.state = ST_CODE;
                end
            endcase
        end else begin
            // end of text: report what is still open, then start afresh
            case (r_st.state)
                ST_STR, ST_STR_ESC: begin
                    n_bnd.mask[KIND_STR_OPEN] = 1'b1;
                    lit_err = 1'b1;
                end
                ST_CHR, ST_CHR_ESC, ST_CHR_CLOSE: begin
                    n_bnd.mask[KIND_BAD_CHR] = 1'b1;
                    lit_err = 1'b1;
                end
                ST_BLK, ST_BLK_STAR: begin
                    n_bnd.mask[KIND_CMT_OPEN] = 1'b1;
                    lit_err = 1'b1;
                end
                default: begin
                    lit_err = 1'b0;
                end
            endcase
            n_bnd.mask[KIND_PARENS]   = (r_st.paren != 16'sd0);
            n_bnd.mask[KIND_BRACKETS] = (r_st.bracket != 16'sd0);
            n_bnd.mask[KIND_BRACES]   = (r_st.brace != 16'sd0);
            n_bnd.mask[KIND_TOTAL]    = 1'b1;
            err_cnt = 3'(lit_err) + 3'(n_bnd.mask[KIND_PARENS])
                    + 3'(n_bnd.mask[KIND_BRACKETS]) + 3'(n_bnd.mask[KIND_BRACES]);
            err_sum = {1'b0, r_st.err} + 17'(err_cnt);
            n_bnd.total = (err_sum > 17'(ERR_MAX)) ? ERR_MAX : err_sum[15:0];
            n_st = rst_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= rst_st;
            r_pend_v <= 1'b0;
        end else begin
            if (accept) r_st <= n_st;
            if (accept && (n_bnd.mask != '0)) begin
                r_pend_v <= 1'b1;
            end else if (i_pend_take) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (n_bnd.mask != '0)) r_pend <= n_bnd;
    end

endmodule

/* hw/rtl/c_sbc_emit.sv */
// ---------------------------------------------------------------------------
// C source balance checker result emitter
// Holds one bundle and sends its results one per transfer, in kind order.
// ---------------------------------------------------------------------------
module c_sbc_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pend_valid,
    input  c_sbc_pkg::t_bundle i_pend,
    output logic               o_pend_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_kind,
    output logic [31:0]        o_line_number,
    output logic signed [15:0] o_amount,
    output logic               o_last_of_run
);
    import c_sbc_pkg::*;

    t_bundle              r_bnd;
    logic [NUM_KINDS-1:0] r_mask, rest;
    logic                 out_acc, free;
    logic [2:0]           kind;

    assign rest        = r_mask & (r_mask - NUM_KINDS'(1));
    assign o_out_valid = (r_mask != '0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign free        = !o_out_valid || (out_acc && (rest == '0));
    assign o_pend_take = free && i_pend_valid;

    // lowest pending kind goes first
    always_comb begin
        kind = KIND_STR_OPEN;
        for (int i = NUM_KINDS - 1; i >= 0; i--) begin
            if (r_mask[i]) kind = 3'(i);
        end
    end

    always_comb begin
        case (kind)
            KIND_PARENS:   o_amount = r_bnd.paren;
            KIND_BRACKETS: o_amount = r_bnd.bracket;
            KIND_BRACES:   o_amount = r_bnd.brace;
            KIND_TOTAL:    o_amount = $signed(r_bnd.total);
            default:       o_amount = 16'sd0;
        endcase
    end

    assign o_kind        = kind;
    assign o_line_number = r_bnd.line_number;
    assign o_last_of_run = (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (o_pend_take) begin
            r_mask <= i_pend.mask;
        end else if (out_acc) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pend_take) r_bnd <= i_pend;
    end

endmodule

/* hw/rtl/c_source_balance_checker_top.sv */
// ---------------------------------------------------------------------------
// C source balance checker
// Scans C source bytes and reports literal, comment and bracket balance faults.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while o_in_stall is low; the lexer state and
// counters update in the cycle of the transfer. Results leave one per cycle
// from the output register while i_out_stall is low: a bad character
// literal gives one result, end of text gives one to five (open literal or
// comment, nonzero paren, bracket and brace counts, then the error total,
// with last_of_run on the final one). A pending result bundle sits between
// lexer and output, so input keeps flowing while a result waits; input is
// held only while that pending bundle is full and the output is still busy
// with an earlier run, so the output drain sets when input moves again.
module c_source_balance_checker_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [7:0]         i_text_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_kind,
    output logic [31:0]        o_line_number,
    output logic signed [15:0] o_amount,
    output logic               o_last_of_run
);
    import c_sbc_pkg::*;

    t_bundle pend;
    logic    pend_valid, pend_take;

    c_sbc_lexer u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_text_byte  (i_text_byte),
        .o_pend_valid (pend_valid),
        .o_pend       (pend),
        .i_pend_take  (pend_take)
    );

    c_sbc_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pend_valid  (pend_valid),
        .i_pend        (pend),
        .o_pend_take   (pend_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_line_number (o_line_number),
        .o_amount      (o_amount),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* hw/rtl/c_sbc_checker.sv */
// ---------------------------------------------------------------------------
// C source balance checker port checks
// Concurrent checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
module c_sbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_func,
    input logic [7:0]         i_text_byte,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_kind,
    input logic [31:0]        o_line_number,
    input logic signed [15:0] o_amount,
    input logic               o_last_of_run
);
    import c_sbc_pkg::*;

    // a stalled input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_func)
            && $stable(i_text_byte))
        else $error("stalled input changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_amount) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // the error total always closes its run
    a_total_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_TOTAL) |-> o_last_of_run)
        else $error("total not last of run");

    // a run is sent without gaps
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=> o_out_valid)
        else $error("gap inside a run");

    // error total is never negative and the line number never zero
    a_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_number != 32'd0)
            && ((o_kind != KIND_TOTAL) || (o_amount >= 16'sd0)))
        else $error("result value out of range");

endmodule

bind c_source_balance_checker_top c_sbc_checker u_chk (.*);
